// ===== design/bas_pkg.sv =====
// bas_pkg: shared types and constants for the best alignment selector
// candidate key, queue entry, combine mode codes and the ranking function
// no dependencies
package bas_pkg;

	localparam logic [1:0] MODE_SINGLE = 2'd0;
	localparam logic [1:0] MODE_SUM    = 2'd1;
	localparam logic [1:0] MODE_MAX    = 2'd2;

	localparam int EDIT_W  = 12;
	localparam int QUAL_W  = 8;
	localparam int RAND_W  = 16;
	localparam int INDEX_W = 4;
	localparam int TIED_W  = 5;

	localparam int QUEUE_DEPTH = 2;

	typedef struct packed {
		logic                proper;
		logic [1:0]          unmapped;
		logic [EDIT_W:0]     edits;
		logic [QUAL_W:0]     quality;
	} bas_key_t;

	typedef struct packed {
		bas_key_t            key;
		logic [RAND_W-1:0]   rnd;
		logic                last;
	} bas_item_t;

	localparam int RANK_W = $bits(bas_key_t);

	// larger word ranks higher: proper, fewer unmapped, fewer edits, more quality
	function automatic logic [RANK_W-1:0] rank_word(input bas_key_t k);
		rank_word = {k.proper, ~k.unmapped, ~k.edits, k.quality};
	endfunction

endpackage

// ===== design/bas_front.sv =====
// bas_front: request intake, combine_mode register and key classification
// depends on bas_pkg
module bas_front (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [1:0]                   cfg_data,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic                         proper_pair,
	input  logic                         first_unmapped,
	input  logic [bas_pkg::EDIT_W-1:0]   first_edits,
	input  logic [bas_pkg::QUAL_W-1:0]   first_quality,
	input  logic                         second_unmapped,
	input  logic [bas_pkg::EDIT_W-1:0]   second_edits,
	input  logic [bas_pkg::QUAL_W-1:0]   second_quality,
	input  logic [bas_pkg::RAND_W-1:0]   random_value,
	input  logic                         last,
	output logic                         push_valid,
	input  logic                         push_ready,
	output bas_pkg::bas_item_t           push_item
);
	import bas_pkg::*;

	logic [1:0]        mode_q;
	bas_key_t          key;
	logic [EDIT_W-1:0] e1_m;
	logic [EDIT_W-1:0] e2_m;
	logic [EDIT_W-1:0] e_min;
	logic [QUAL_W-1:0] q_max;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_SUM;
		end else if (cfg_valid) begin
			mode_q <= cfg_data;
		end
	end

	assign e1_m  = first_unmapped ? '0 : first_edits;
	assign e2_m  = second_unmapped ? '0 : second_edits;
	assign e_min = (first_edits < second_edits) ? first_edits : second_edits;
	assign q_max = (first_quality > second_quality) ? first_quality : second_quality;

	always_comb begin
		key = '0;
		unique case (mode_q)
			MODE_SINGLE: begin
				key.proper   = 1'b1;
				key.unmapped = {1'b0, first_unmapped};
				key.edits    = {1'b0, e1_m};
				key.quality  = {1'b0, first_quality};
			end
			MODE_MAX: begin
				key.proper  = proper_pair;
				key.quality = {1'b0, q_max};
				if (first_unmapped && second_unmapped) begin
					key.unmapped = 2'd2;
					key.edits    = '0;
				end else begin
					key.unmapped = 2'd0;
					if (first_unmapped) begin
						key.edits = {1'b0, second_edits};
					end else if (second_unmapped) begin
						key.edits = {1'b0, first_edits};
					end else begin
						key.edits = {1'b0, e_min};
					end
				end
			end
			default: begin
				key.proper   = proper_pair;
				key.unmapped = {1'b0, first_unmapped} + {1'b0, second_unmapped};
				key.edits    = {1'b0, e1_m} + {1'b0, e2_m};
				key.quality  = {1'b0, first_quality} + {1'b0, second_quality};
			end
		endcase
	end

	assign in_ready       = push_ready;
	assign push_valid     = in_valid;
	assign push_item.key  = key;
	assign push_item.rnd  = random_value;
	assign push_item.last = last;

endmodule

// ===== design/bas_queue.sv =====
// bas_queue: short register queue between the front and back parts
// depends on bas_pkg
module bas_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push_valid,
	output logic                push_ready,
	input  bas_pkg::bas_item_t  push_item,
	output logic                pop_valid,
	input  logic                pop_ready,
	output bas_pkg::bas_item_t  pop_item
);
	import bas_pkg::*;

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

	bas_item_t        slot_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             push;
	logic             pop;

	assign push_ready = (count_q != CNT_FULL);
	assign pop_valid  = (count_q != '0);
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;
	assign pop_item   = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ===== design/bas_back.sv =====
// bas_back: running best-key compare, tie count, reservoir pick and result register
// depends on bas_pkg
module bas_back #(
	parameter int MAX_CANDIDATES = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          pop_valid,
	output logic                          pop_ready,
	input  bas_pkg::bas_item_t            pop_item,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [bas_pkg::INDEX_W-1:0]   best_index,
	output logic [bas_pkg::TIED_W-1:0]    tied_count
);
	import bas_pkg::*;

	localparam int PW = $clog2(MAX_CANDIDATES + 1);
	localparam logic [PW-1:0] POS_MAX = PW'(MAX_CANDIDATES);

	bas_key_t             best_q;
	logic [PW-1:0]        pos_q;
	logic [PW-1:0]        chosen_q;
	logic [PW-1:0]        tie_q;
	logic                 out_valid_q;
	logic [INDEX_W-1:0]   best_index_q;
	logic [TIED_W-1:0]    tied_count_q;

	logic                 pop;
	logic                 active;
	logic                 better;
	logic                 equal;
	logic [PW-1:0]        tie_inc;
	logic [RAND_W+PW-1:0] product;
	logic                 pick;
	logic                 take_new;
	logic [PW-1:0]        chosen_n;
	logic [PW-1:0]        tie_n;

	assign pop_ready = !out_valid_q || out_ready;
	assign pop       = pop_valid && pop_ready;
	assign active    = (pos_q < POS_MAX);
	assign better    = rank_word(pop_item.key) > rank_word(best_q);
	assign equal     = (pop_item.key == best_q);
	assign tie_inc   = tie_q + 1'b1;
	assign product   = (RAND_W+PW)'(pop_item.rnd) * (RAND_W+PW)'(tie_inc);
	assign pick      = (product[RAND_W+PW-1:RAND_W] == '0);
	assign take_new  = active && ((pos_q == '0) || better);

	always_comb begin
		chosen_n = chosen_q;
		tie_n    = tie_q;
		if (take_new) begin
			chosen_n = pos_q;
			tie_n    = PW'(1);
		end else if (active && equal) begin
			tie_n = tie_inc;
			if (pick) begin
				chosen_n = pos_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop && pop_item.last) begin
			best_index_q <= INDEX_W'(chosen_n);
			tied_count_q <= TIED_W'(tie_n);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			best_q      <= '0;
			pos_q       <= '0;
			chosen_q    <= '0;
			tie_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop && take_new) begin
				best_q <= pop_item.key;
			end
			if (pop) begin
				chosen_q <= chosen_n;
				tie_q    <= tie_n;
				if (pop_item.last) begin
					pos_q <= '0;
				end else if (active) begin
					pos_q <= pos_q + 1'b1;
				end
			end
			if (pop && pop_item.last) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid  = out_valid_q;
	assign best_index = best_index_q;
	assign tied_count = tied_count_q;

endmodule

// ===== design/best_alignment_selector.sv =====
// best_alignment_selector: picks the best candidate alignment of each group
// a result is registered in bas_back after the last request of its group is written into a queue slot and popped
// throughput: one request per cycle unless a held result stalls it, set by the compare and update loop in bas_back
// a two-entry queue decouples intake from the compare stage; a held result stalls intake once full
// reset: best key, tie count and position cleared, combine_mode set to paired sum; no clearing pass
// depends on bas_pkg, bas_front, bas_queue, bas_back
module best_alignment_selector #(
	parameter int MAX_CANDIDATES = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [1:0]                    cfg_data,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic                          proper_pair,
	input  logic                          first_unmapped,
	input  logic [bas_pkg::EDIT_W-1:0]    first_edits,
	input  logic [bas_pkg::QUAL_W-1:0]    first_quality,
	input  logic                          second_unmapped,
	input  logic [bas_pkg::EDIT_W-1:0]    second_edits,
	input  logic [bas_pkg::QUAL_W-1:0]    second_quality,
	input  logic [bas_pkg::RAND_W-1:0]    random_value,
	input  logic                          last,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [bas_pkg::INDEX_W-1:0]   best_index,
	output logic [bas_pkg::TIED_W-1:0]    tied_count
);
	import bas_pkg::*;

	logic      push_valid;
	logic      push_ready;
	bas_item_t push_item;
	logic      pop_valid;
	logic      pop_ready;
	bas_item_t pop_item;

	bas_front u_front (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_valid       (cfg_valid),
		.cfg_ready       (cfg_ready),
		.cfg_data        (cfg_data),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.proper_pair     (proper_pair),
		.first_unmapped  (first_unmapped),
		.first_edits     (first_edits),
		.first_quality   (first_quality),
		.second_unmapped (second_unmapped),
		.second_edits    (second_edits),
		.second_quality  (second_quality),
		.random_value    (random_value),
		.last            (last),
		.push_valid      (push_valid),
		.push_ready      (push_ready),
		.push_item       (push_item)
	);

	bas_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_item  (push_item),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_item   (pop_item)
	);

	bas_back #(
		.MAX_CANDIDATES (MAX_CANDIDATES)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_item   (pop_item),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.best_index (best_index),
		.tied_count (tied_count)
	);

endmodule
